### rtl/core/sidta_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidta_pkg: shared types and constants for the decimal text converter
// Widths, character codes and the sequencer state type used by the
// converter top level and its shift-and-adjust unit.
// ----------------------------------------------------------------------------
package sidta_pkg;

	// Width of the signed input value.
	localparam int unsigned VALUE_W = 32;
	// Decimal digits needed for the largest magnitude, 2147483648.
	localparam int unsigned DIGITS  = 10;
	localparam int unsigned BCD_W   = 4 * DIGITS;
	// Width of the step counter of the shift-and-adjust pass, one step per magnitude bit.
	localparam int unsigned STEP_W  = $clog2(VALUE_W);
	localparam int unsigned IDX_W   = $clog2(DIGITS);

	// Output character field and its padded bus width.
	localparam int unsigned CHAR_W  = 6;
	localparam int unsigned TDATA_W = 8;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);
	localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(45);

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SCAN,
		ST_EMIT
	} state_t;

endpackage

### rtl/core/sidta_dabble.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidta_dabble: one shift-and-adjust step of binary to BCD conversion
// Every BCD digit of five or more gets three added, then the digit string
// and the remaining binary bits shift left by one as a single word.
// ----------------------------------------------------------------------------
module sidta_dabble (
	input  logic [sidta_pkg::BCD_W-1:0]   bcd,
	input  logic [sidta_pkg::VALUE_W-1:0] bin,
	output logic [sidta_pkg::BCD_W-1:0]   bcd_next,
	output logic [sidta_pkg::VALUE_W-1:0] bin_next
);

	logic [sidta_pkg::BCD_W-1:0] adj;

	// The digits are independent lanes.
	always_comb begin
		for (int i = 0; i < sidta_pkg::DIGITS; i++) begin
			if (bcd[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd[4*i +: 4];
			end
		end
	end

	assign bcd_next = {adj[sidta_pkg::BCD_W-2:0], bin[sidta_pkg::VALUE_W-1]};
	assign bin_next = {bin[sidta_pkg::VALUE_W-2:0], 1'b0};

endmodule

### rtl/core/signed_int_to_decimal_ascii.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: signed 32-bit integer to decimal ASCII text
// Converts one two's complement value per input beat into its decimal text,
// most significant character first, with a leading minus for negatives.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel (s_tvalid, s_tready, s_tdata) takes one signed 32-bit
//   value per beat. The master channel (m_tvalid, m_tready, m_tdata, m_tlast)
//   returns between 1 and 11 character beats for that value: a minus sign
//   for negative values, then the digits with no leading zeros ("0" for
//   zero). m_tlast marks the final digit; no terminator is sent.
//   Timing: after a value is accepted, the magnitude passes 32 times through
//   one shift-and-adjust unit (one bit per cycle), a scan state finds the
//   leading digit, and then one character leaves per cycle while the
//   receiver is ready. s_tready is high only while the block is idle,
//   which includes the time the final character still waits in the output
//   register, so the next value's conversion overlaps that wait.
//   Reset (arst_n low) drops any value in progress and empties the output
//   register. When the receiver stalls, the output register holds its beat
//   and the sequencer waits with it.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [sidta_pkg::VALUE_W-1:0]   s_tdata,  // [31:0] value
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [sidta_pkg::TDATA_W-1:0]   m_tdata,  // [5:0] character, [7:6] zero
	output logic                            m_tlast   // last character of the value
);

	sidta_pkg::state_t state_q, state_d;

	logic [sidta_pkg::VALUE_W-1:0] bin_q;
	logic [sidta_pkg::BCD_W-1:0]   bcd_q;
	logic [sidta_pkg::STEP_W-1:0]  cnt_q;
	logic [sidta_pkg::IDX_W-1:0]   idx_q;
	logic                          sign_q;

	logic [sidta_pkg::BCD_W-1:0]   bcd_step;
	logic [sidta_pkg::VALUE_W-1:0] bin_step;

	logic                          m_tvalid_q;
	logic [sidta_pkg::CHAR_W-1:0]  char_q;
	logic                          last_q;

	logic                          in_fire;
	logic                          out_load;
	logic [sidta_pkg::IDX_W-1:0]   lead_idx;
	logic [3:0]                    digit;
	logic [3:0]                    digits [sidta_pkg::DIGITS];

	// The shared arithmetic unit: one shift-and-adjust step per cycle while converting.
	sidta_dabble u_dabble (
		.bcd      (bcd_q),
		.bin      (bin_q),
		.bcd_next (bcd_step),
		.bin_next (bin_step)
	);

	assign in_fire  = s_tvalid && s_tready;
	// In the emit state the output register may take a new beat when it is empty or draining.
	assign out_load = (state_q == sidta_pkg::ST_EMIT) && (!m_tvalid_q || m_tready);

	// Split the BCD word into digits and find the most significant nonzero
	// one. A value of zero leaves the index at the units digit.
	always_comb begin
		lead_idx = '0;
		for (int i = 0; i < sidta_pkg::DIGITS; i++) begin
			digits[i] = bcd_q[4*i +: 4];
			if (bcd_q[4*i +: 4] != 4'd0) begin
				lead_idx = sidta_pkg::IDX_W'(i);
			end
		end
	end

	assign digit = digits[idx_q];

	// Sequencer: next state.
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		unique case (state_q)
			sidta_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = sidta_pkg::ST_CONV;
				end
			end
			sidta_pkg::ST_CONV: begin
				if (cnt_q == sidta_pkg::STEP_W'(sidta_pkg::VALUE_W - 1)) begin
					state_d = sidta_pkg::ST_SCAN;
				end
			end
			sidta_pkg::ST_SCAN: begin
				state_d = sidta_pkg::ST_EMIT;
			end
			sidta_pkg::ST_EMIT: begin
				if (out_load && !sign_q && idx_q == '0) begin
					state_d = sidta_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sidta_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sidta_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath. On accept the magnitude is formed as an unsigned negation,
	// so the most negative value needs no special handling.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			sign_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			if (in_fire) begin
				sign_q <= s_tdata[sidta_pkg::VALUE_W-1];
				cnt_q  <= '0;
			end else if (state_q == sidta_pkg::ST_CONV) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (state_q == sidta_pkg::ST_SCAN) begin
				idx_q <= lead_idx;
			end else if (out_load) begin
				if (sign_q) begin
					sign_q <= 1'b0;
				end else if (idx_q != '0) begin
					idx_q <= idx_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			bcd_q <= '0;
			if (s_tdata[sidta_pkg::VALUE_W-1]) begin
				bin_q <= ~s_tdata + 1'b1;
			end else begin
				bin_q <= s_tdata;
			end
		end else if (state_q == sidta_pkg::ST_CONV) begin
			bcd_q <= bcd_step;
			bin_q <= bin_step;
		end
	end

	// Output register: the minus sign first when pending, then digits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (sign_q) begin
				char_q <= sidta_pkg::CHAR_MINUS;
				last_q <= 1'b0;
			end else begin
				char_q <= sidta_pkg::CHAR_ZERO + {2'b00, digit};
				last_q <= (idx_q == '0);
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(sidta_pkg::TDATA_W - sidta_pkg::CHAR_W){1'b0}}, char_q};
	assign m_tlast  = last_q;

	// An accepted value always starts a fresh conversion pass.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q == sidta_pkg::ST_CONV && cnt_q == '0)
		else $error("accepted value did not start a conversion");

	// Every magnitude bit has been shifted into the BCD digits by the scan.
	a_bits_consumed: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sidta_pkg::ST_SCAN |-> bin_q == '0)
		else $error("binary bits left after the conversion pass");

	// The pass ends after exactly one step per magnitude bit.
	a_pass_length: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sidta_pkg::ST_CONV &&
		cnt_q == sidta_pkg::STEP_W'(sidta_pkg::VALUE_W - 1)
		|=> state_q == sidta_pkg::ST_SCAN)
		else $error("conversion pass length wrong");

	// A minus sign is never the final character.
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[sidta_pkg::CHAR_W-1:0] == sidta_pkg::CHAR_MINUS |-> !m_tlast)
		else $error("minus sign flagged as last character");

	// Once the minus sign is out, the digit selected for output is nine or less.
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sidta_pkg::ST_EMIT && !sign_q |-> digit <= 4'd9)
		else $error("BCD digit out of range");

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for signed_int_to_decimal_ascii
// Streams signed 32-bit values into the converter and checks every character
// beat that comes back against decimal text predicted here. A short directed
// table covers zero, one digit, the ten-digit extremes and the most negative
// value. Random values then follow, with random idle gaps on the sender,
// random back-pressure on the receiver, one long receiver hold-off and one
// full drain in the middle of the run.
// ----------------------------------------------------------------------------
module testbench;

	localparam int DIRECTED_COUNT = 19;
	localparam int RANDOM_COUNT   = 420;
	localparam int HOLD_CYCLES    = 400;
	localparam int TAIL_CYCLES    = 60;
	localparam int CYCLE_LIMIT    = 1000000;
	localparam int REPORT_LIMIT   = 10;
	localparam int DECIMAL_BASE   = 10;

	// One expected character beat: the ASCII code and the end-of-text flag.
	typedef struct packed {
		logic [sidta_pkg::CHAR_W-1:0] ch;
		logic                         last;
	} text_beat_t;

	// A directed row. A nonzero text holds the expected characters,
	// right-justified; a zero text means the predictor works it out.
	typedef struct packed {
		logic [sidta_pkg::VALUE_W-1:0] value;
		logic [87:0]                   text;
	} directed_row_t;

	logic                          clk;
	logic                          arst_n   = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [sidta_pkg::VALUE_W-1:0] s_tdata  = '0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [sidta_pkg::TDATA_W-1:0] m_tdata;
	logic                          m_tlast;

	text_beat_t    expected_text [$];
	directed_row_t directed_rows [DIRECTED_COUNT];
	int            error_count     = 0;
	int            cycle_count     = 0;
	// Shaping knobs shared between the sender and the receiver processes.
	bit            tx_steady       = 1'b0;
	bit            rx_steady       = 1'b0;
	bit            rx_hold_request = 1'b0;

	signed_int_to_decimal_ascii dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // [31:0] value
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // [5:0] character, [7:6] zero
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// The run must end on its own well before this; hitting it is a hang.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d beats still expected",
				cycle_count, expected_text.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Predicts the text of one value. The magnitude is taken as an unsigned
	// negation, so the most negative value needs no special handling.
	function automatic void predict_text(input logic [sidta_pkg::VALUE_W-1:0] value);
		logic [sidta_pkg::VALUE_W-1:0] magnitude;
		logic [3:0]                    digits [sidta_pkg::DIGITS];
		int                            count;
		text_beat_t                    beat;
		magnitude = value[sidta_pkg::VALUE_W-1] ? (~value + 1'b1) : value;
		count = 0;
		do begin
			digits[count] = 4'(magnitude % DECIMAL_BASE);
			count++;
			magnitude = magnitude / DECIMAL_BASE;
		end while (magnitude != 0);
		if (value[sidta_pkg::VALUE_W-1]) begin
			beat.ch = sidta_pkg::CHAR_MINUS;
			beat.last = 1'b0;
			expected_text.push_back(beat);
		end
		for (int i = count - 1; i >= 0; i--) begin
			beat.ch = sidta_pkg::CHAR_ZERO + sidta_pkg::CHAR_W'(digits[i]);
			beat.last = (i == 0);
			expected_text.push_back(beat);
		end
	endfunction

	// Mostly short gaps, a few long ones, none at all in a steady stretch.
	function automatic int pick_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (tx_steady || pick < 55)
			return 0;
		else if (pick < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 50);
	endfunction

	function automatic void log_failure(input string msg);
		error_count++;
		if (error_count <= REPORT_LIMIT)
			$display("ERROR at %0t: %s", $realtime, msg);
	endfunction

	// Offers one value until it is accepted, then idles for a drawn gap.
	// Valid stays high into the next item unless a gap is drawn.
	task automatic send_value(input logic [sidta_pkg::VALUE_W-1:0] value);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata <= value;
		do @(posedge clk); while (!s_tready);
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			s_tdata <= $urandom;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stops offering and waits until every predicted beat has come back.
	task automatic wait_text_drained();
		s_tvalid <= 1'b0;
		while (expected_text.size() != 0)
			@(posedge clk);
	endtask

	// Receiver: random back-pressure, with a long hold-off on request. The
	// hold-off is counted here so the sender keeps offering meanwhile.
	initial begin
		int stall_left;
		int pick;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rx_hold_request) begin
				rx_hold_request = 1'b0;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (rx_steady) begin
				m_tready <= 1'b1;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					m_tready <= 1'b1;
				end else begin
					stall_left = (pick < 97) ? $urandom_range(0, 2) : $urandom_range(9, 39);
					m_tready <= 1'b0;
				end
			end
		end
	end

	// Checker: every accepted character beat is compared with the oldest
	// prediction. The two pad bits of the data byte must be zero.
	always @(posedge clk) begin
		text_beat_t beat;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_text.size() == 0) begin
				log_failure($sformatf("unexpected beat data=%h last=%b", m_tdata, m_tlast));
			end else begin
				beat = expected_text.pop_front();
				if (m_tdata !== {2'b00, beat.ch} || m_tlast !== beat.last)
					log_failure($sformatf("expected char=%0d last=%b, got data=%h last=%b",
						beat.ch, beat.last, m_tdata, m_tlast));
			end
		end
	end

	// Stimulus. Each value's text is queued before the value is offered, so
	// the prediction is in place whatever gap follows the accepting edge.
	initial begin
		logic [sidta_pkg::VALUE_W-1:0] value;
		logic [sidta_pkg::VALUE_W-1:0] scale;
		int                            pick;
		text_beat_t                    beat;

		// Rows with typed text are the ones readable at a glance; the rest
		// go through the predictor.
		directed_rows = '{
			'{32'd0,           "0"},
			'{32'd1,           "1"},
			'{-32'sd1,         "-1"},
			'{32'd9,           "9"},
			'{32'd10,          "10"},
			'{-32'sd10,        "-10"},
			'{32'h7FFF_FFFF,   "2147483647"},
			'{32'h8000_0000,   "-2147483648"},
			'{32'h8000_0001,   "-2147483647"},
			'{32'd1000000000,  "1000000000"},
			'{-32'sd1000000000, "-1000000000"},
			'{32'd999999999,   88'd0},
			'{-32'sd999999999, 88'd0},
			'{32'd123456789,   88'd0},
			'{-32'sd987654321, 88'd0},
			'{32'd100,         88'd0},
			'{-32'sd100,       88'd0},
			'{32'h5555_5555,   88'd0},
			'{32'hAAAA_AAAA,   88'd0}
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIRECTED_COUNT; r++) begin
			if (directed_rows[r].text == '0) begin
				predict_text(directed_rows[r].value);
			end else begin
				// Walk the packed string from its first nonzero byte down.
				for (int b = 10; b >= 0; b--) begin
					if (directed_rows[r].text[b*8 +: 8] != 8'd0) begin
						beat.ch = directed_rows[r].text[b*8 +: sidta_pkg::CHAR_W];
						beat.last = (b == 0);
						expected_text.push_back(beat);
					end
				end
			end
			send_value(directed_rows[r].value);
		end

		for (int n = 0; n < RANDOM_COUNT; n++) begin
			// Now and then switch either side into a stretch with no idling.
			if (n % 50 == 0) begin
				tx_steady = ($urandom_range(0, 3) == 0);
				rx_steady = ($urandom_range(0, 3) == 0);
			end
			// The receiver holds off for a long time while values keep coming.
			if (n == 100)
				rx_hold_request = 1'b1;
			// The sender stops until the converter has emptied completely.
			if (n == 250)
				wait_text_drained();

			pick = $urandom_range(0, 99);
			scale = 1;
			repeat ($urandom_range(0, 9)) scale = scale * DECIMAL_BASE;
			if (pick < 35) begin
				value = $urandom;
			end else if (pick < 65) begin
				// Short numbers of every length, zero included.
				value = $urandom_range(0, scale - 1);
				if ($urandom_range(0, 1))
					value = ~value + 1'b1;
			end else if (pick < 85) begin
				// Powers of ten and their neighbors, where the digit count changes.
				value = scale + $urandom_range(0, 2) - 1;
				if ($urandom_range(0, 1))
					value = ~value + 1'b1;
			end else begin
				value = $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 20)
				                             : 32'h7FFF_FFFF - $urandom_range(0, 20);
			end
			predict_text(value);
			send_value(value);
		end

		wait_text_drained();
		// Leave room for any stray beat to show up after the last one.
		repeat (TAIL_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### signed_int_to_decimal_ascii.f
rtl/core/sidta_pkg.sv
rtl/core/sidta_dabble.sv
rtl/core/signed_int_to_decimal_ascii.sv
dv/testbench.sv
